/* rtl/lpt_pkg.sv */
// shared constants, types and codes for the lru page tag cache
package lpt_pkg;

	// built depth and stamp width
	localparam int ENTRIES    = 16;
	localparam int STAMP_BITS = 32;

	// field widths
	localparam int OP_W      = 2;
	localparam int PID_W     = 16;
	localparam int PAGE_W    = 16;
	localparam int OUT_IDX_W = 4;
	localparam int CFG_W     = 5;

	// derived widths
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// register reset value
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	// opcodes
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INVAL  = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

	// search token handed from cell to cell
	typedef struct packed {
		logic                  found;
		logic [IDX_W-1:0]      hit_idx;
		logic                  free;
		logic [IDX_W-1:0]      free_idx;
		logic [STAMP_BITS-1:0] best_stamp;
		logic [IDX_W-1:0]      best_idx;
	} lpt_tok_t;

	// token entering the first cell: nothing found, best stamp at all ones
	localparam lpt_tok_t TOK_INIT = '{
		found:      1'b0,
		hit_idx:    '0,
		free:       1'b0,
		free_idx:   '0,
		best_stamp: '1,
		best_idx:   '0
	};

	// update command broadcast to every cell
	typedef struct packed {
		logic                  wr_en;
		logic [IDX_W-1:0]      wr_idx;
		logic                  wr_tags;
		logic [PID_W-1:0]      wr_pid;
		logic [PAGE_W-1:0]     wr_page;
		logic [STAMP_BITS-1:0] wr_stamp;
		logic                  inv_en;
		logic [PID_W-1:0]      inv_pid;
		logic                  flush;
	} lpt_cmd_t;

endpackage

/* rtl/lru_page_tag_cache.sv */
// top level: fully associative tag cache with lru replacement
//
// Input channel (in_valid / in_stall) takes one beat of opcode, process_id
// and page_number. Output channel (out_valid / out_stall) returns one beat
// of hit and entry_index for every input beat, in order.
// A lookup walks a search token down a row of ENTRIES cells, one cell per
// cycle, then writes the hit or victim entry back and passes the result
// through the done state to the output register; the next beat is taken
// once the result has been handed to the output register.
// Invalidate and flush act on all cells at once and the unused opcode does
// nothing; these skip the search and go straight to the done state.
// One item is worked on at a time; in_stall is high while an item is in
// flight. The result sits in an output register, so a stalled receiver
// holds it there and the item behind it waits to hand over its result.
// cfg_we / cfg_data write entries_in_use; the user must do so only while idle, the block does not enforce it.
// Reset empties every entry, sets the stamp counter to one and
// entries_in_use to 16; no clearing pass is needed.
module lru_page_tag_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpt_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lpt_pkg::OP_W-1:0]       opcode,
	input  logic [lpt_pkg::PID_W-1:0]      process_id,
	input  logic [lpt_pkg::PAGE_W-1:0]     page_number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [lpt_pkg::OUT_IDX_W-1:0]  entry_index
);
	import lpt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_DONE   = 3'b100
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CFG_W-1:0]         cfg_q;
	logic [STAMP_BITS-1:0]    stamp_cnt_q;
	logic [PID_W-1:0]         q_pid_q;
	logic [PAGE_W-1:0]        q_page_q;
	logic                     res_hit_q;
	logic [IDX_W-1:0]         res_idx_q;
	logic                     out_valid_q;
	logic                     out_hit_q;
	logic [IDX_W-1:0]         out_idx_q;

	logic                     in_acc;
	logic                     srch_done;
	logic                     out_take;
	logic [CNT_W-1:0]         act_n;
	logic [IDX_W-1:0]         tgt_idx;
	logic [IDX_W+OUT_IDX_W-1:0] idx_ext;
	lpt_tok_t                 last_tok;
	lpt_cmd_t                 cmd;
	lpt_tok_t                 tok_in  [ENTRIES];
	lpt_tok_t                 tok_out [ENTRIES];

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign idx_ext   = {OUT_IDX_W'(0), out_idx_q};
	assign entry_index = idx_ext[OUT_IDX_W-1:0];

	// active entry count, clamped to one..ENTRIES
	always_comb begin
		if (cfg_q == '0) begin
			act_n = CNT_W'(1);
		end else if (32'(cfg_q) > 32'(ENTRIES)) begin
			act_n = CNT_W'(ENTRIES);
		end else begin
			act_n = CNT_W'(cfg_q);
		end
	end

	// result of the walk and the entry to write
	assign last_tok  = tok_out[ENTRIES-1];
	assign srch_done = (state_q == ST_SEARCH) && (cnt_q == CNT_W'(ENTRIES));

	always_comb begin
		priority if (last_tok.found) begin
			tgt_idx = last_tok.hit_idx;
		end else if (last_tok.free) begin
			tgt_idx = last_tok.free_idx;
		end else begin
			tgt_idx = last_tok.best_idx;
		end
	end

	// command broadcast to the cells
	always_comb begin
		cmd.wr_en    = srch_done;
		cmd.wr_idx   = tgt_idx;
		cmd.wr_tags  = !last_tok.found;
		cmd.wr_pid   = q_pid_q;
		cmd.wr_page  = q_page_q;
		cmd.wr_stamp = stamp_cnt_q;
		cmd.inv_en   = in_acc && (opcode == OP_INVAL);
		cmd.inv_pid  = process_id;
		cmd.flush    = in_acc && (opcode == OP_FLUSH);
	end

	// row of cells
	assign tok_in[0] = TOK_INIT;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i > 0) begin : g_link
			assign tok_in[i] = tok_out[i-1];
		end
		lpt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.act_n    (act_n),
			.q_pid    (q_pid_q),
			.q_page   (q_page_q),
			.tok_in   (tok_in[i]),
			.cmd      (cmd),
			.tok_out  (tok_out[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0;
						if (opcode == OP_LOOKUP) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SEARCH: begin
					if (srch_done) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// stamp counter and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_cnt_q <= STAMP_BITS'(1);
			cfg_q       <= CFG_RESET;
		end else begin
			if (srch_done) begin
				stamp_cnt_q <= stamp_cnt_q + STAMP_BITS'(1);
			end
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
		end
	end

	// query and pending result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			q_pid_q   <= process_id;
			q_page_q  <= page_number;
			res_hit_q <= 1'b0;
			res_idx_q <= '0;
		end else if (srch_done) begin
			res_hit_q <= last_tok.found;
			res_idx_q <= tgt_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_take) begin
			out_hit_q <= res_hit_q;
			out_idx_q <= res_idx_q;
		end
	end

endmodule

/* rtl/lpt_cell.sv */
// one cache entry with its stage of the search chain
module lpt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lpt_pkg::IDX_W-1:0]     cell_idx,
	input  logic [lpt_pkg::CNT_W-1:0]     act_n,
	input  logic [lpt_pkg::PID_W-1:0]     q_pid,
	input  logic [lpt_pkg::PAGE_W-1:0]    q_page,
	input  lpt_pkg::lpt_tok_t             tok_in,
	input  lpt_pkg::lpt_cmd_t             cmd,
	output lpt_pkg::lpt_tok_t             tok_out
);
	import lpt_pkg::*;

	logic                  valid_q;
	logic [PID_W-1:0]      pid_q;
	logic [PAGE_W-1:0]     page_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  active;
	lpt_tok_t              tok_nxt;
	lpt_tok_t              tok_q;

	assign active = CNT_W'(cell_idx) < act_n;

	// fold this entry into the passing token
	always_comb begin
		tok_nxt = tok_in;
		if (active) begin
			if (valid_q && (pid_q == q_pid) && (page_q == q_page) && !tok_in.found) begin
				tok_nxt.found   = 1'b1;
				tok_nxt.hit_idx = cell_idx;
			end
			if (!valid_q && !tok_in.free) begin
				tok_nxt.free     = 1'b1;
				tok_nxt.free_idx = cell_idx;
			end
			// ties go to the later entry
			if (valid_q && (stamp_q <= tok_in.best_stamp)) begin
				tok_nxt.best_stamp = stamp_q;
				tok_nxt.best_idx   = cell_idx;
			end
		end
	end

	// token stage register
	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign tok_out = tok_q;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (cmd.flush) begin
				valid_q <= 1'b0;
			end else if (cmd.inv_en && valid_q && (pid_q == cmd.inv_pid)) begin
				valid_q <= 1'b0;
			end else if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
				valid_q <= 1'b1;
			end
		end
	end

	// tags and use stamp, stamp freed on clear
	always_ff @(posedge clk) begin
		priority if (cmd.flush) begin
			stamp_q <= '0;
		end else if (cmd.inv_en && valid_q && (pid_q == cmd.inv_pid)) begin
			stamp_q <= '0;
		end else if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
			stamp_q <= cmd.wr_stamp;
			if (cmd.wr_tags) begin
				pid_q  <= cmd.wr_pid;
				page_q <= cmd.wr_page;
			end
		end
	end

endmodule

/* rtl/lpt_checker.sv */
// port-level checks for the lru page tag cache, bound to the top level
module lpt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [lpt_pkg::OP_W-1:0]       opcode,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           hit,
	input  logic [lpt_pkg::OUT_IDX_W-1:0]  entry_index
);
	import lpt_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(entry_index))
		else $error("stalled result beat changed");

	// one item in flight: no beat taken right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input beat taken while busy");

	// non-lookup ops answer miss at entry zero, through the done state and the output register
	a_other_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode != OP_LOOKUP) && !out_valid
		|-> ##2 (out_valid && !hit && (entry_index == '0)))
		else $error("invalidate or flush result wrong");

	// a lookup cannot answer in the next cycle
	a_lookup_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_LOOKUP) && !out_valid |=> !out_valid)
		else $error("lookup answered too early");

endmodule

bind lru_page_tag_cache lpt_checker u_lpt_checker (.*);

/* tb/lru_page_tag_cache_tb.sv */
// testbench for the lru page tag cache: queued stimulus, tag-store prediction and beat checking
`timescale 1ns / 1ps

module lru_page_tag_cache_tb;
	import lpt_pkg::*;

	// opcode with no defined action
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 62;
	localparam int LONG_HOLD      = 200;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [PID_W-1:0]  process_id;
		logic [PAGE_W-1:0] page_number;
	} tag_req_t;

	typedef struct packed {
		logic                 hit;
		logic [OUT_IDX_W-1:0] entry_index;
	} tag_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode = '0;
	logic [PID_W-1:0]     process_id = '0;
	logic [PAGE_W-1:0]    page_number = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic [OUT_IDX_W-1:0] entry_index;

	// predicted tag store
	bit                  ent_valid [ENTRIES];
	bit [PID_W-1:0]      ent_pid [ENTRIES];
	bit [PAGE_W-1:0]     ent_page [ENTRIES];
	bit [STAMP_BITS-1:0] ent_stamp [ENTRIES];
	bit [STAMP_BITS-1:0] next_stamp = 1;
	bit [CFG_W-1:0]      active_cfg = CFG_RESET;

	tag_req_t    pending_requests [$];
	tag_result_t expected_results [$];
	tag_req_t    drive_req;
	int          beats_outstanding = 0;
	int          fail_count = 0;
	bit          in_taken = 1'b0;
	bit          quiet = 1'b0;
	bit          hold_request = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          hold_left = 0;

	// per-phase tag pools so lookups revisit the same pages
	bit [PID_W-1:0]  pid_pool [4];
	bit [PAGE_W-1:0] page_pool [24];

	bit [CFG_W-1:0] active_plan [PHASES] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd7,
		5'd12, 5'd16, 5'd2, 5'd24, 5'd5, 5'd16};

	lru_page_tag_cache DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.process_id  (process_id),
		.page_number (page_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.entry_index (entry_index)
	);

	always #5 clk = ~clk;

	function automatic void clear_slot(input int i);
		ent_valid[i] = 1'b0;
		ent_pid[i]   = '0;
		ent_page[i]  = '0;
		ent_stamp[i] = '0;
	endfunction

	// one request against the predicted store, returning its result beat
	function automatic tag_result_t predict_tag_access(input tag_req_t req);
		tag_result_t         res;
		int                  n;
		int                  slot;
		bit                  found;
		bit                  have_free;
		bit [STAMP_BITS-1:0] low_stamp;
		res = '0;
		found = 1'b0;
		have_free = 1'b0;
		slot = 0;
		low_stamp = '0;
		case (req.opcode)
			OP_LOOKUP: begin
				n = (active_cfg == 0) ? 1 : (active_cfg > ENTRIES) ? ENTRIES : int'(active_cfg);
				for (int i = 0; i < n; i++)
					if (!found && ent_valid[i] && ent_pid[i] == req.process_id &&
							ent_page[i] == req.page_number) begin
						found = 1'b1;
						slot = i;
					end
				if (!found) begin
					// victim: first free active entry, else oldest stamp, later index on a tie
					for (int i = 0; i < n; i++)
						if (!have_free) begin
							if (!ent_valid[i]) begin
								have_free = 1'b1;
								slot = i;
							end else if (i == 0 || ent_stamp[i] <= low_stamp) begin
								low_stamp = ent_stamp[i];
								slot = i;
							end
						end
					ent_valid[slot] = 1'b1;
					ent_pid[slot]   = req.process_id;
					ent_page[slot]  = req.page_number;
				end
				ent_stamp[slot] = next_stamp;
				next_stamp++;
				res.hit = found;
				res.entry_index = OUT_IDX_W'(slot);
			end
			OP_INVAL: begin
				for (int i = 0; i < ENTRIES; i++)
					if (ent_valid[i] && ent_pid[i] == req.process_id)
						clear_slot(i);
			end
			OP_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++)
					clear_slot(i);
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic tag_req_t random_request(input int page_span);
		tag_req_t req;
		int       pick;
		pick = $urandom_range(0, 99);
		req.process_id  = PID_W'($urandom);
		req.page_number = PAGE_W'($urandom);
		if (pick < 74) begin
			req.opcode      = OP_LOOKUP;
			req.process_id  = pid_pool[$urandom_range(0, 3)];
			req.page_number = page_pool[$urandom_range(0, page_span)];
		end else if (pick < 82) begin
			req.opcode = OP_LOOKUP;
		end else if (pick < 92) begin
			req.opcode = OP_INVAL;
			if ($urandom_range(0, 3) != 0)
				req.process_id = pid_pool[$urandom_range(0, 3)];
		end else if (pick < 96) begin
			req.opcode = OP_FLUSH;
		end else begin
			req.opcode = OP_SPARE;
		end
		return req;
	endfunction

	task automatic queue_request(input tag_req_t req);
		pending_requests.push_back(req);
		beats_outstanding++;
	endtask

	task automatic wait_drained();
		while (beats_outstanding != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_active_count(input bit [CFG_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// request side: hold each beat until taken, with random gaps
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(0, 7);
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				drive_req = pending_requests.pop_front();
				in_valid    <= 1'b1;
				opcode      <= drive_req.opcode;
				process_id  <= drive_req.process_id;
				page_number <= drive_req.page_number;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side: random stall bursts and one long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// sample config writes, accepted requests and result beats
	always @(posedge clk) begin
		tag_result_t exp_res;
		if (arst_n) begin
			if (cfg_we)
				active_cfg = cfg_data;
			in_taken = in_valid && !in_stall;
			if (in_taken)
				expected_results.push_back(predict_tag_access('{opcode, process_id,
					page_number}));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: hit %0d entry_index %0d",
						hit, entry_index);
					fail_count++;
				end else begin
					exp_res = expected_results.pop_front();
					beats_outstanding--;
					if (hit !== exp_res.hit) begin
						$error("hit: expected %0d, got %0d", exp_res.hit, hit);
						fail_count++;
					end
					if (entry_index !== exp_res.entry_index) begin
						$error("entry_index: expected %0d, got %0d",
							exp_res.entry_index, entry_index);
						fail_count++;
					end
				end
			end
		end
	end

	// stimulus sequence
	initial begin
		int page_span;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, hit, free-slot refill, invalidate, spare opcode, flush
		write_active_count(5'd16);
		queue_request('{OP_LOOKUP, 16'h0000, 16'h0000});
		queue_request('{OP_LOOKUP, 16'hFFFF, 16'hFFFF});
		queue_request('{OP_LOOKUP, 16'h0000, 16'h0000});
		queue_request('{OP_LOOKUP, 16'h0000, 16'hFFFF});
		queue_request('{OP_LOOKUP, 16'hFFFF, 16'h0000});
		queue_request('{OP_INVAL, 16'hFFFF, 16'h1234});
		queue_request('{OP_LOOKUP, 16'hFFFF, 16'hFFFF});
		queue_request('{OP_INVAL, 16'h5A5A, 16'h0000});
		queue_request('{OP_SPARE, 16'h0000, 16'h0000});
		queue_request('{OP_SPARE, 16'hFFFF, 16'hFFFF});
		queue_request('{OP_LOOKUP, 16'h0000, 16'h0000});
		queue_request('{OP_FLUSH, 16'hFFFF, 16'hFFFF});
		queue_request('{OP_LOOKUP, 16'h0000, 16'h0000});
		queue_request('{OP_LOOKUP, 16'hFFFF, 16'hFFFF});

		// random phases over a spread of active counts, last one with no idling
		for (int p = 0; p < PHASES; p++) begin
			write_active_count(active_plan[p]);
			if (p == 1)
				hold_request = 1'b1;
			if (p == PHASES - 1)
				quiet = 1'b1;
			foreach (pid_pool[i])
				pid_pool[i] = PID_W'($urandom);
			foreach (page_pool[i])
				page_pool[i] = PAGE_W'($urandom);
			page_span = $urandom_range(2, 23);
			for (int k = 0; k < PHASE_ITEMS; k++)
				queue_request(random_request(page_span));
		end

		wait_drained();
		repeat (30) @(negedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
